// File: rtl/core/nnis_pkg.sv
// ---------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants for the nearest-neighbor image scaler.
// ---------------------------------------------------------------------------
package nnis_pkg;

    // Default size limits
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_DIM    = 4096;

    // Channel layout of one stored pixel word
    localparam int MAX_CHANNELS = 4;
    localparam int NUM_CHAN     = 4;
    localparam int CHAN_W       = 8;
    localparam int WORD_W       = NUM_CHAN * CHAN_W;

    // Fixed field widths
    localparam int POS_W      = 12;
    localparam int SRC_DIM_W  = 9;
    localparam int DST_DIM_W  = 13;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH     = 3'd0,
        REG_SRC_HEIGHT    = 3'd1,
        REG_DST_WIDTH     = 3'd2,
        REG_DST_HEIGHT    = 3'd3,
        REG_CHANNEL_COUNT = 3'd4
    } cfg_reg_t;

    // Item kinds
    typedef enum logic {
        KIND_LOAD    = 1'b0,
        KIND_REQUEST = 1'b1
    } kind_t;

    // Control that travels along the pipeline with each item
    typedef struct packed {
        logic vld;  // live item in this stage
        logic req;  // request (read), else load (write)
        logic bad;  // request outside the destination frame
    } ctl_t;

endpackage

// File: rtl/core/nnis_ram.sv
// ---------------------------------------------------------------------------
// nnis_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module nnis_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 65536,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
        rdata_reg <= store_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/nnis_div.sv
// ---------------------------------------------------------------------------
// nnis_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num < den << QUO_W and holds den stable while items are in
// flight. One new dividend every cycle.
// ---------------------------------------------------------------------------
module nnis_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 13,
    parameter int QUO_W = 8
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [CW-1:0]    rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [CW-1:0]    den_sh;
        logic             take;
        logic [CW-1:0]    rem_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = CW'(num);
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Trial subtract of the shifted divisor
        assign den_sh   = CW'(den) << (QUO_W - 1 - k);
        assign take     = (rem_in >= den_sh);
        assign rem_next = take ? (rem_in - den_sh) : rem_in;
        assign quo_next = (quo_in << 1) | QUO_W'(take);

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// File: rtl/core/nearest_neighbor_image_scaler.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor resampler over a source frame held in one RAM.
// Pipeline: the entry registers, the control delay line beside the coordinate
//   dividers, the frame store read and the result registers; QW is the quotient
//   width of the coordinate dividers (8 with defaults).
// Throughput: one item per cycle; busy never rises and done cannot stall.
// The pipelined dividers and the single RAM port each take one item a cycle.
// Reset clears the pipeline control and returns configuration to its defaults; the
//   frame store stays unknown until each pixel is loaded.
// ---------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
    parameter int MAX_SRC_WIDTH  = nnis_pkg::MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = nnis_pkg::MAX_SRC_HEIGHT,
    parameter int MAX_DST_DIM    = nnis_pkg::MAX_DST_DIM
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Item channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [nnis_pkg::POS_W-1:0]      pos_x,
    input  logic [nnis_pkg::POS_W-1:0]      pos_y,
    input  logic [nnis_pkg::CHAN_W-1:0]     in_chan0,
    input  logic [nnis_pkg::CHAN_W-1:0]     in_chan1,
    input  logic [nnis_pkg::CHAN_W-1:0]     in_chan2,
    input  logic [nnis_pkg::CHAN_W-1:0]     in_chan3,
    // Result channel
    output logic                            done,
    output logic [nnis_pkg::CHAN_W-1:0]     out_chan0,
    output logic [nnis_pkg::CHAN_W-1:0]     out_chan1,
    output logic [nnis_pkg::CHAN_W-1:0]     out_chan2,
    output logic [nnis_pkg::CHAN_W-1:0]     out_chan3,
    output logic                            bad_coordinate,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SW_W    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DD_W    = $clog2(MAX_DST_DIM + 1);
    localparam int XW      = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
    localparam int YW      = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
    localparam int QW      = (XW > YW) ? XW : YW;
    localparam int DEPTH   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PXW     = nnis_pkg::POS_W + SW_W;
    localparam int PYW     = nnis_pkg::POS_W + SH_W;
    localparam int LATENCY = QW + 3;
    localparam int CHAN_W  = nnis_pkg::CHAN_W;
    localparam int WORD_W  = nnis_pkg::WORD_W;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [nnis_pkg::SRC_DIM_W-1:0] src_width_reg;
    logic [nnis_pkg::SRC_DIM_W-1:0] src_height_reg;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_width_reg;
    logic [nnis_pkg::DST_DIM_W-1:0] dst_height_reg;
    logic [nnis_pkg::CNT_W-1:0]     channel_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= nnis_pkg::SRC_DIM_W'(256);
            src_height_reg    <= nnis_pkg::SRC_DIM_W'(256);
            dst_width_reg     <= nnis_pkg::DST_DIM_W'(256);
            dst_height_reg    <= nnis_pkg::DST_DIM_W'(256);
            channel_count_reg <= nnis_pkg::CNT_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nnis_pkg::REG_SRC_WIDTH:
                    src_width_reg <= cfg_data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_SRC_HEIGHT:
                    src_height_reg <= cfg_data[nnis_pkg::SRC_DIM_W-1:0];
                nnis_pkg::REG_DST_WIDTH:
                    dst_width_reg <= cfg_data[nnis_pkg::DST_DIM_W-1:0];
                nnis_pkg::REG_DST_HEIGHT:
                    dst_height_reg <= cfg_data[nnis_pkg::DST_DIM_W-1:0];
                nnis_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[nnis_pkg::CNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Sizes saturated to their legal ranges, zero counts as one
    logic [31:0]               sw_wide, sh_wide, dw_wide, dh_wide;
    logic [SW_W-1:0]           sw;
    logic [SH_W-1:0]           sh;
    logic [DD_W-1:0]           dw, dh;
    logic [nnis_pkg::CNT_W-1:0] nch;

    always_comb
    begin
        sw_wide = (src_width_reg == '0) ? 32'd1 :
                  (32'(src_width_reg) > 32'(MAX_SRC_WIDTH)) ? 32'(MAX_SRC_WIDTH) :
                  32'(src_width_reg);
        sh_wide = (src_height_reg == '0) ? 32'd1 :
                  (32'(src_height_reg) > 32'(MAX_SRC_HEIGHT)) ? 32'(MAX_SRC_HEIGHT) :
                  32'(src_height_reg);
        dw_wide = (dst_width_reg == '0) ? 32'd1 :
                  (32'(dst_width_reg) > 32'(MAX_DST_DIM)) ? 32'(MAX_DST_DIM) :
                  32'(dst_width_reg);
        dh_wide = (dst_height_reg == '0) ? 32'd1 :
                  (32'(dst_height_reg) > 32'(MAX_DST_DIM)) ? 32'(MAX_DST_DIM) :
                  32'(dst_height_reg);
        if (channel_count_reg == '0)
        begin
            nch = nnis_pkg::CNT_W'(1);
        end
        else if (32'(channel_count_reg) > 32'(nnis_pkg::MAX_CHANNELS))
        begin
            nch = nnis_pkg::CNT_W'(nnis_pkg::MAX_CHANNELS);
        end
        else
        begin
            nch = channel_count_reg;
        end
    end

    assign sw = sw_wide[SW_W-1:0];
    assign sh = sh_wide[SH_W-1:0];
    assign dw = dw_wide[DD_W-1:0];
    assign dh = dh_wide[DD_W-1:0];

    // -----------------------------------------------------------------------
    // Entry stage: classify the item, scale the coordinates
    // -----------------------------------------------------------------------
    logic              accept;
    logic              is_req;
    logic              ld_in_frame;
    logic              out_of_frame;
    nnis_pkg::ctl_t    ctl_next;
    logic [ADDR_W-1:0] ld_addr_next;
    logic [WORD_W-1:0] ld_data_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_req = (kind == nnis_pkg::KIND_REQUEST);

    always_comb
    begin
        ld_in_frame  = (32'(pos_x) < 32'(sw)) && (32'(pos_y) < 32'(sh));
        out_of_frame = (32'(pos_x) >= 32'(dw)) || (32'(pos_y) >= 32'(dh));
        ctl_next.vld = accept && (is_req || ld_in_frame);
        ctl_next.req = is_req;
        ctl_next.bad = is_req && out_of_frame;
        ld_addr_next = ADDR_W'(32'(pos_y[YW-1:0]) * 32'(MAX_SRC_WIDTH)
                               + 32'(pos_x[XW-1:0]));
        ld_data_next = {in_chan3, in_chan2, in_chan1, in_chan0};
    end

    // Control delay line, aligned with the divider stages
    nnis_pkg::ctl_t    ctl_reg     [QW+1];
    logic [ADDR_W-1:0] ld_addr_reg [QW+1];
    logic [WORD_W-1:0] ld_data_reg [QW+1];
    logic [PXW-1:0]    prod_x_reg;
    logic [PYW-1:0]    prod_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_next;
            for (int k = 1; k <= QW; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Load payload travels alongside so writes land in item order
    always_ff @(posedge clk)
    begin
        prod_x_reg     <= PXW'(32'(pos_x) * 32'(sw));
        prod_y_reg     <= PYW'(32'(pos_y) * 32'(sh));
        ld_addr_reg[0] <= ld_addr_next;
        ld_data_reg[0] <= ld_data_next;
        for (int k = 1; k <= QW; k++)
        begin
            ld_addr_reg[k] <= ld_addr_reg[k-1];
            ld_data_reg[k] <= ld_data_reg[k-1];
        end
    end

    // -----------------------------------------------------------------------
    // Coordinate dividers: src = dst * src_size / dst_size
    // -----------------------------------------------------------------------
    logic [QW-1:0] quo_x, quo_y;

    nnis_div #(
        .NUM_W (PXW),
        .DEN_W (DD_W),
        .QUO_W (QW)
    ) u_div_x (
        .clk (clk),
        .num (prod_x_reg),
        .den (dw),
        .quo (quo_x)
    );

    nnis_div #(
        .NUM_W (PYW),
        .DEN_W (DD_W),
        .QUO_W (QW)
    ) u_div_y (
        .clk (clk),
        .num (prod_y_reg),
        .den (dh),
        .quo (quo_y)
    );

    // -----------------------------------------------------------------------
    // Frame store access: loads write, requests read, one per cycle
    // -----------------------------------------------------------------------
    nnis_pkg::ctl_t    ram_ctl;
    logic [ADDR_W-1:0] req_addr;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [WORD_W-1:0] rd_data;

    assign ram_ctl  = ctl_reg[QW];
    assign req_addr = ADDR_W'(32'(quo_y[YW-1:0]) * 32'(MAX_SRC_WIDTH)
                              + 32'(quo_x[XW-1:0]));
    assign ram_addr = ram_ctl.req ? req_addr : ld_addr_reg[QW];
    assign ram_we   = ram_ctl.vld && !ram_ctl.req;

    nnis_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ld_data_reg[QW]),
        .rdata (rd_data)
    );

    // -----------------------------------------------------------------------
    // Result stage: mask unused channels, zero on a bad coordinate
    // -----------------------------------------------------------------------
    nnis_pkg::ctl_t    rd_ctl_reg;
    logic              done_reg;
    logic              done_next;
    logic              bad_reg;
    logic [CHAN_W-1:0] out_chan_reg  [nnis_pkg::NUM_CHAN];
    logic [CHAN_W-1:0] out_chan_next [nnis_pkg::NUM_CHAN];

    assign done_next = rd_ctl_reg.vld && rd_ctl_reg.req;

    always_comb
    begin
        for (int c = 0; c < nnis_pkg::NUM_CHAN; c++)
        begin
            if (!rd_ctl_reg.bad && (nnis_pkg::CNT_W'(c) < nch))
            begin
                out_chan_next[c] = rd_data[c*CHAN_W +: CHAN_W];
            end
            else
            begin
                out_chan_next[c] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_ctl_reg <= ram_ctl;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg <= rd_ctl_reg.bad;
        for (int c = 0; c < nnis_pkg::NUM_CHAN; c++)
        begin
            out_chan_reg[c] <= out_chan_next[c];
        end
    end

    assign done           = done_reg;
    assign bad_coordinate = bad_reg;
    assign out_chan0      = out_chan_reg[0];
    assign out_chan1      = out_chan_reg[1];
    assign out_chan2      = out_chan_reg[2];
    assign out_chan3      = out_chan_reg[3];

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_coordinate) |->
            (out_chan0 == '0 && out_chan1 == '0 && out_chan2 == '0 && out_chan3 == '0))
        else $error("bad coordinate result carries nonzero channels");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == nnis_pkg::KIND_LOAD) |-> ##LATENCY !done)
        else $error("load produced a result");

    a_req_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == nnis_pkg::KIND_REQUEST
         && 32'(pos_x) < 32'(dw) && 32'(pos_y) < 32'(dh))
            |-> ##LATENCY (done && !bad_coordinate))
        else $error("in-frame request result missing or flagged");

    a_req_out_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == nnis_pkg::KIND_REQUEST
         && (32'(pos_x) >= 32'(dw) || 32'(pos_y) >= 32'(dh)))
            |-> ##LATENCY (done && bad_coordinate))
        else $error("out-of-frame request not flagged");

endmodule

// File: verif/tb_nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nearest_neighbor_image_scaler
// Self-checking testbench for the nearest-neighbor image scaler. A shadow
// copy of the frame store and the size registers predicts every request
// result; a monitor compares each done strobe against the oldest prediction.
// Directed tests cover frame corners, dropped loads, out-of-frame requests,
// register saturation and pixel retention across size changes. Random phases
// then sweep many geometries under different amounts of sender idling.
// ---------------------------------------------------------------------------
module tb_nearest_neighbor_image_scaler;
    import nnis_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 100;
    localparam int STORE_WORDS    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int PHASE_ITEMS    = 110;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 3'd7;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        pixel_t           chan;
    } scaler_item_t;

    typedef struct packed {
        pixel_t chan;
        logic   bad;
    } scaled_pixel_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  kind      = 1'b0;
    logic [POS_W-1:0]      pos_x     = '0;
    logic [POS_W-1:0]      pos_y     = '0;
    logic [CHAN_W-1:0]     in_chan0  = '0;
    logic [CHAN_W-1:0]     in_chan1  = '0;
    logic [CHAN_W-1:0]     in_chan2  = '0;
    logic [CHAN_W-1:0]     in_chan3  = '0;
    logic                  done;
    logic [CHAN_W-1:0]     out_chan0;
    logic [CHAN_W-1:0]     out_chan1;
    logic [CHAN_W-1:0]     out_chan2;
    logic [CHAN_W-1:0]     out_chan3;
    logic                  bad_coordinate;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow registers, held at their port widths
    logic [SRC_DIM_W-1:0] shadow_src_width     = 9'd256;
    logic [SRC_DIM_W-1:0] shadow_src_height    = 9'd256;
    logic [DST_DIM_W-1:0] shadow_dst_width     = 13'd256;
    logic [DST_DIM_W-1:0] shadow_dst_height    = 13'd256;
    logic [CNT_W-1:0]     shadow_channel_count = 3'd3;

    // Shadow frame store and which words hold a loaded pixel
    pixel_t frame_mirror [STORE_WORDS];
    bit     frame_loaded [STORE_WORDS];

    scaled_pixel_t expected_pixels [$];
    int            mismatch_count  = 0;
    int            sender_idle_pct = 0;
    int            idle_cycles     = 0;

    nearest_neighbor_image_scaler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .in_chan0       (in_chan0),
        .in_chan1       (in_chan1),
        .in_chan2       (in_chan2),
        .in_chan3       (in_chan3),
        .done           (done),
        .out_chan0      (out_chan0),
        .out_chan1      (out_chan1),
        .out_chan2      (out_chan2),
        .out_chan3      (out_chan3),
        .bad_coordinate (bad_coordinate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Size in use: zero counts as one, large values clip to the limit
    function automatic int unsigned eff_size(input cfg_reg_t which);
        int unsigned raw;
        int unsigned hi;
        case (which)
            REG_SRC_WIDTH:  begin raw = 32'(shadow_src_width);  hi = MAX_SRC_WIDTH;  end
            REG_SRC_HEIGHT: begin raw = 32'(shadow_src_height); hi = MAX_SRC_HEIGHT; end
            REG_DST_WIDTH:  begin raw = 32'(shadow_dst_width);  hi = MAX_DST_DIM;    end
            REG_DST_HEIGHT: begin raw = 32'(shadow_dst_height); hi = MAX_DST_DIM;    end
            default:        begin raw = 32'(shadow_channel_count); hi = MAX_CHANNELS; end
        endcase
        if (raw < 1)
            return 1;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    function automatic bit in_dst_frame(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        return (32'(x) < eff_size(REG_DST_WIDTH)) && (32'(y) < eff_size(REG_DST_HEIGHT));
    endfunction

    // Store address of the source pixel that a destination position maps to
    function automatic int unsigned mapped_addr(input logic [POS_W-1:0] x,
                                                input logic [POS_W-1:0] y);
        int unsigned xu;
        int unsigned yu;
        int unsigned sx;
        int unsigned sy;
        xu = 32'(x);
        yu = 32'(y);
        sx = (xu * eff_size(REG_SRC_WIDTH)) / eff_size(REG_DST_WIDTH);
        sy = (yu * eff_size(REG_SRC_HEIGHT)) / eff_size(REG_DST_HEIGHT);
        return sy * MAX_SRC_WIDTH + sx;
    endfunction

    // Update the shadow frame or queue the expected pixel for one transfer
    function automatic void apply_item(input scaler_item_t item);
        scaled_pixel_t want;
        int unsigned   addr;
        int unsigned   nch;
        pixel_t        word;
        if (item.kind == KIND_LOAD)
        begin
            if (32'(item.x) < eff_size(REG_SRC_WIDTH)
                && 32'(item.y) < eff_size(REG_SRC_HEIGHT))
            begin
                addr = 32'(item.y) * MAX_SRC_WIDTH + 32'(item.x);
                frame_mirror[addr] = item.chan;
                frame_loaded[addr] = 1'b1;
            end
        end
        else
        begin
            want.chan = '0;
            want.bad  = !in_dst_frame(item.x, item.y);
            if (!want.bad)
            begin
                addr = mapped_addr(item.x, item.y);
                word = frame_mirror[addr];
                nch  = eff_size(REG_CHANNEL_COUNT);
                for (int c = 0; c < NUM_CHAN; c++)
                    if (c < nch)
                        want.chan[c] = word[c];
            end
            expected_pixels.push_back(want);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------

    // One item transfer, with random idle cycles ahead of it
    task automatic send_item(input scaler_item_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        kind     <= item.kind;
        pos_x    <= item.x;
        pos_y    <= item.y;
        in_chan0 <= item.chan[0];
        in_chan1 <= item.chan[1];
        in_chan2 <= item.chan[2];
        in_chan3 <= item.chan[3];
        do
            @(posedge clk);
        while (busy);
        apply_item(item);
    endtask

    task automatic send_load(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input pixel_t pixel);
        scaler_item_t item;
        item.kind = KIND_LOAD;
        item.x    = x;
        item.y    = y;
        item.chan = pixel;
        send_item(item);
    endtask

    // Request; the channel inputs carry noise since they are ignored
    task automatic send_request(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        scaler_item_t item;
        item.kind = KIND_REQUEST;
        item.x    = x;
        item.y    = y;
        item.chan = $urandom;
        send_item(item);
    endtask

    // Request that loads its source pixel first if it was never written
    task automatic request_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        int unsigned addr;
        if (in_dst_frame(x, y))
        begin
            addr = mapped_addr(x, y);
            if (!frame_loaded[addr])
                send_load(POS_W'(addr % MAX_SRC_WIDTH), POS_W'(addr / MAX_SRC_WIDTH),
                          $urandom);
        end
        send_request(x, y);
    endtask

    // Hold off the sender until every expected result is in and the pipe is empty
    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write transfer; only called with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SRC_WIDTH:     shadow_src_width     = data[SRC_DIM_W-1:0];
            REG_SRC_HEIGHT:    shadow_src_height    = data[SRC_DIM_W-1:0];
            REG_DST_WIDTH:     shadow_dst_width     = data[DST_DIM_W-1:0];
            REG_DST_HEIGHT:    shadow_dst_height    = data[DST_DIM_W-1:0];
            REG_CHANNEL_COUNT: shadow_channel_count = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                                input int unsigned dw, input int unsigned dh,
                                input int unsigned nch);
        wait_results_drained();
        cfg_write(REG_SRC_WIDTH, CFG_DATA_W'(sw));
        cfg_write(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
        cfg_write(REG_DST_WIDTH, CFG_DATA_W'(dw));
        cfg_write(REG_DST_HEIGHT, CFG_DATA_W'(dh));
        cfg_write(REG_CHANNEL_COUNT, CFG_DATA_W'(nch));
    endtask

    // One random item; dropped loads do not count toward the phase length
    task automatic random_item(output bit counted);
        int unsigned      sw;
        int unsigned      sh;
        int unsigned      dw;
        int unsigned      dh;
        int unsigned      pick;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        sw      = eff_size(REG_SRC_WIDTH);
        sh      = eff_size(REG_SRC_HEIGHT);
        dw      = eff_size(REG_DST_WIDTH);
        dh      = eff_size(REG_DST_HEIGHT);
        pick    = $urandom_range(99);
        counted = 1'b1;
        x       = POS_W'($urandom);
        y       = POS_W'($urandom);
        if (pick < 55)
            request_pixel(POS_W'($urandom_range(dw - 1)), POS_W'($urandom_range(dh - 1)));
        else if (pick < 75)
            send_load(POS_W'($urandom_range(sw - 1)), POS_W'($urandom_range(sh - 1)),
                      $urandom);
        else if (pick < 88 && (dw < MAX_DST_DIM || dh < MAX_DST_DIM))
        begin
            // one coordinate past the destination edge
            if (dw < MAX_DST_DIM && (dh >= MAX_DST_DIM || $urandom_range(1)))
                x = POS_W'($urandom_range(MAX_DST_DIM - 1, dw));
            else
                y = POS_W'($urandom_range(MAX_DST_DIM - 1, dh));
            send_request(x, y);
        end
        else
        begin
            // load past the source edge, dropped by the block
            if ($urandom_range(1))
                x = POS_W'($urandom_range(MAX_DST_DIM - 1, sw));
            else
                y = POS_W'($urandom_range(MAX_DST_DIM - 1, sh));
            send_load(x, y, $urandom);
            counted = 1'b0;
        end
    endtask

    task automatic random_items(input int count);
        int done_items;
        bit counted;
        done_items = 0;
        while (done_items < count)
        begin
            random_item(counted);
            if (counted)
                done_items++;
        end
    endtask

    // Random traffic under one geometry; the sender pauses halfway for a full drain
    task automatic run_random_phase(input int unsigned sw, input int unsigned sh,
                                    input int unsigned dw, input int unsigned dh,
                                    input int unsigned nch, input int count);
        set_geometry(sw, sh, dw, dh, nch);
        random_items(count / 2);
        wait_results_drained();
        random_items(count - count / 2);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset geometry: frame corners, dropped loads, out-of-frame requests
    task automatic test_default_frame();
        send_load(0, 0, 32'hFFFF_FFFF);
        send_load(255, 255, 32'h0000_0000);
        send_load(255, 0, 32'hC33C_5AA5);
        send_load(0, 255, 32'hFE7F_8001);
        send_load(0, 1, 32'h1234_5678);
        // would alias onto (0,1) and (0,255) if the block wrapped the address
        send_load(256, 0, 32'hDEAD_BEEF);
        send_load(0, 4095, 32'hBAD0_0BAD);
        request_pixel(0, 0);
        request_pixel(255, 255);
        request_pixel(255, 0);
        request_pixel(0, 255);
        request_pixel(0, 1);
        send_request(256, 0);
        send_request(0, 256);
        send_request(4095, 4095);
    endtask

    // Zero and oversized register values, masked high bits, unmapped index
    task automatic test_register_saturation();
        wait_results_drained();
        cfg_write(REG_SRC_WIDTH, 13'h0000);
        cfg_write(REG_SRC_HEIGHT, 13'h1FFF);
        cfg_write(REG_DST_WIDTH, 13'h1FFF);
        cfg_write(REG_DST_HEIGHT, 13'h0000);
        cfg_write(REG_CHANNEL_COUNT, 13'h0000);
        request_pixel(4095, 0);
        request_pixel(2048, 0);
        send_request(0, 1);
        send_load(1, 0, $urandom);
        send_load(0, 200, $urandom);

        wait_results_drained();
        cfg_write(REG_SRC_WIDTH, 13'h012C);
        cfg_write(REG_DST_HEIGHT, 13'h1001);
        cfg_write(REG_CHANNEL_COUNT, 13'h0007);
        request_pixel(4095, 4095);
        request_pixel(4095, 2048);

        wait_results_drained();
        cfg_write(REG_CHANNEL_COUNT, 13'h0005);
        cfg_write(UNMAPPED_REG, 13'h1FFF);
        request_pixel(0, 0);

        wait_results_drained();
        cfg_write(REG_SRC_WIDTH, 13'h1E40);
        request_pixel(100, 0);
    endtask

    // Pixels keep their position when the source size changes
    task automatic test_frame_retention();
        set_geometry(8, 8, 8, 8, 4);
        send_load(5, 3, 32'h8040_2010);
        set_geometry(200, 100, 200, 100, 4);
        request_pixel(5, 3);
        request_pixel(0, 1);
    endtask

    task automatic test_random_scaling();
        sender_idle_pct = 24;
        run_random_phase(13, 7, 40, 21, 2, PHASE_ITEMS);
        run_random_phase(256, 256, 4096, 4096, 4, PHASE_ITEMS);
        run_random_phase(200, 150, 3, 5, 1, PHASE_ITEMS);
        sender_idle_pct = 62;
        run_random_phase(1, 1, 4096, 1, 4, PHASE_ITEMS);
        run_random_phase(37, 256, 100, 300, 3, PHASE_ITEMS);
        sender_idle_pct = 0;
        run_random_phase(5, 9, 4096, 17, 4, PHASE_ITEMS);
        run_random_phase(256, 1, 7, 4096, 2, PHASE_ITEMS);
        run_random_phase(64, 48, 160, 120, 4, PHASE_ITEMS);
    endtask

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    // Compare every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        scaled_pixel_t want;
        pixel_t        got;
        if (rst_n && done)
        begin
            got = {out_chan3, out_chan2, out_chan1, out_chan0};
            if (expected_pixels.size() == 0)
                report_mismatch("result with nothing expected, channels", got, '0);
            else
            begin
                want = expected_pixels.pop_front();
                for (int c = 0; c < NUM_CHAN; c++)
                    if (got[c] !== want.chan[c])
                        report_mismatch($sformatf("out_chan%0d", c), 32'(got[c]),
                                        32'(want.chan[c]));
                if (bad_coordinate !== want.bad)
                    report_mismatch("bad_coordinate", 32'(bad_coordinate), 32'(want.bad));
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_nearest_neighbor_image_scaler: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 24;
        test_default_frame();
        test_register_saturation();
        test_frame_retention();
        test_random_scaling();
        wait_results_drained();
        if (mismatch_count == 0)
            $display("tb_nearest_neighbor_image_scaler: clean");
        else
            $display("tb_nearest_neighbor_image_scaler: errors");
        $finish;
    end

endmodule
